### rtl/ttfe_pkg.sv
`default_nettype none
package ttfe_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 24;
  localparam int DELAY_W    = 15;
  localparam int COEF_W     = 16;
  localparam int GAIN_REG_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int MAX_CH     = 8;
  localparam int CH_W       = 3;
  localparam int OUT_W      = (2 + MAX_CH) * SAMPLE_W;

  // shared multiplier widths
  localparam int OPA_W  = SAMPLE_W + 1;
  localparam int OPB_W  = COEF_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FRAC_W = 15;
  localparam int RND_W  = ACC_W - FRAC_W;

  // defaults for the top level parameters
  localparam int DEF_DEPTH_LOG2 = 15;
  localparam int DEF_CHANNELS   = 8;

  localparam logic [COEF_W-1:0]       ONE_Q15  = COEF_W'(2 ** FRAC_W);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (FRAC_W - 1));

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO_DELAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE_GAINS_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE_GAINS_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO_GAINS_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO_GAINS_HI = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP2,
    ST_SUM,
    ST_F1_MUL,
    ST_F1_RND,
    ST_F1_UPD,
    ST_F2_MUL,
    ST_F2_RND,
    ST_F2_UPD,
    ST_FB_MUL,
    ST_FB_RND,
    ST_FB_WR,
    ST_MIX_A,
    ST_MIX_B,
    ST_MIX_C,
    ST_DONE
  } state_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    OP_F1,
    OP_F2,
    OP_FB,
    OP_T1,
    OP_T2
  } op_sel_t;

  typedef struct packed {
    logic            rd_en;
    logic            rd_sel;
    logic            ld_tap1;
    logic            ld_sum;
    logic            mul_en;
    op_sel_t         op_sel;
    logic            acc_load;
    logic            upd_f1;
    logic            upd_f2;
    logic            mem_we;
    logic            mix_we;
    logic [CH_W-1:0] mix_ch;
    logic [CH_W-1:0] gain_ch;
    logic            out_load;
  } ctrl_t;

  // drop the fraction bits of an accumulator that already holds the rounding half
  function automatic logic signed [RND_W-1:0] shift_q15(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1:FRAC_W];
  endfunction

  // clamp to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [RND_W-1:0] v);
    logic [RND_W-SAMPLE_W:0] top;
    top = v[RND_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      return v[SAMPLE_W-1:0];
    end else if (v[RND_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

### rtl/ttfe_mem.sv
`default_nettype none
module ttfe_mem import ttfe_pkg::*; #(
  parameter int AW = DEF_DEPTH_LOG2
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output logic      [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [0:(2**AW)-1];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/ttfe_mac.sv
`default_nettype none
module ttfe_mac import ttfe_pkg::*; (
  input  wire logic                    clk,
  input  wire ctrl_t                   ctrl,
  input  wire logic signed [OPA_W-1:0] op_a,
  input  wire logic signed [OPB_W-1:0] op_b,
  output logic signed      [ACC_W-1:0] acc,
  output logic signed      [ACC_W-1:0] acc_sum
);

  logic signed [PROD_W-1:0] prod;

  // registered product, then accumulator preloaded with the rounding half
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= op_a * op_b;
    end
    if (ctrl.acc_load) begin
      acc <= ACC_W'(prod) + RND_HALF;
    end
  end

  // second product of a mix added on the fly
  assign acc_sum = acc + ACC_W'(prod);

endmodule
`default_nettype wire

### rtl/ttfe_seq.sv
`default_nettype none
module ttfe_seq import ttfe_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  input  wire logic out_free,
  output logic      s_tready,
  output ctrl_t     ctrl
);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  state_t          state, state_next;
  logic [CH_W-1:0] ch, ch_next;
  logic            last_ch;

  assign last_ch = (ch == LAST_CH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    ch_next    = ch;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_TAP2;
      ST_TAP2:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_F1_MUL;
      ST_F1_MUL: state_next = ST_F1_RND;
      ST_F1_RND: state_next = ST_F1_UPD;
      ST_F1_UPD: state_next = ST_F2_MUL;
      ST_F2_MUL: state_next = ST_F2_RND;
      ST_F2_RND: state_next = ST_F2_UPD;
      ST_F2_UPD: state_next = ST_FB_MUL;
      ST_FB_MUL: state_next = ST_FB_RND;
      ST_FB_RND: state_next = ST_FB_WR;
      ST_FB_WR:  state_next = ST_MIX_A;
      ST_MIX_A:  state_next = ST_MIX_B;
      ST_MIX_B:  state_next = ST_MIX_C;
      ST_MIX_C: begin
        if (last_ch) begin
          state_next = ST_DONE;
          ch_next    = '0;
        end else begin
          state_next = ST_MIX_B;
          ch_next    = ch + 1'b1;
        end
      end
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl     = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        ctrl.rd_en  = s_tvalid;
        ctrl.rd_sel = 1'b0;
      end
      ST_TAP2: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_sel  = 1'b1;
        ctrl.ld_tap1 = 1'b1;
      end
      ST_SUM:    ctrl.ld_sum = 1'b1;
      ST_F1_MUL: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OP_F1;
      end
      ST_F1_RND: ctrl.acc_load = 1'b1;
      ST_F1_UPD: ctrl.upd_f1 = 1'b1;
      ST_F2_MUL: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OP_F2;
      end
      ST_F2_RND: ctrl.acc_load = 1'b1;
      ST_F2_UPD: ctrl.upd_f2 = 1'b1;
      ST_FB_MUL: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OP_FB;
      end
      ST_FB_RND: ctrl.acc_load = 1'b1;
      ST_FB_WR:  ctrl.mem_we = 1'b1;
      ST_MIX_A: begin
        ctrl.mul_en  = 1'b1;
        ctrl.op_sel  = OP_T1;
        ctrl.gain_ch = ch;
      end
      ST_MIX_B: begin
        ctrl.mul_en   = 1'b1;
        ctrl.op_sel   = OP_T2;
        ctrl.gain_ch  = ch;
        ctrl.acc_load = 1'b1;
      end
      ST_MIX_C: begin
        ctrl.mix_we  = 1'b1;
        ctrl.mix_ch  = ch;
        // start tap one of the next channel
        ctrl.mul_en  = !last_ch;
        ctrl.op_sel  = OP_T1;
        ctrl.gain_ch = ch + 1'b1;
      end
      ST_DONE:   ctrl.out_load = out_free;
      default:   ctrl = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/two_tap_feedback_echo_unit.sv
`default_nettype none
// One item is in work at a time; the next item is taken once the result of the last one
// has moved into the output register. Every product goes through the one shared
// multiplier, in order. A finished result waits in the output register while the next
// item is taken.
// Reset (rst, synchronous): control, config, write pointer, wrap flag and filter state
// clear at once; no clearing pass, unwritten memory entries read as zero by pointer/wrap.
module two_tap_feedback_echo_unit import ttfe_pkg::*; #(
  parameter int DEPTH_LOG2 = DEF_DEPTH_LOG2,
  parameter int CHANNELS   = DEF_CHANNELS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SAMPLE_W-1:0]   s_tdata,   // sample_in
  input  wire logic                  s_tlast,   // block_end
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // tap_one_sample, tap_two_sample, channel_0_mix .. channel_7_mix
  output logic [OUT_W-1:0]           m_tdata,
  output logic                       m_tlast,   // block_end_out
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [GAIN_REG_W-1:0] cfg_data
);

  localparam int AW = DEPTH_LOG2;

  ctrl_t ctrl;
  logic  out_free;

  // config registers
  logic [DELAY_W-1:0]    tap_one_delay, tap_two_delay;
  logic [COEF_W-1:0]     feedback_gain, damping_coeff;
  logic [GAIN_REG_W-1:0] tap_one_gains_lo, tap_one_gains_hi;
  logic [GAIN_REG_W-1:0] tap_two_gains_lo, tap_two_gains_hi;

  // item state
  logic                       wrapped;
  logic [AW-1:0]              wp;
  logic signed [SAMPLE_W-1:0] h0, h1, y, t1, t2, x;
  logic                       be;
  logic                       rd_ok;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic [SAMPLE_W-1:0]        mix_work [MAX_CH];

  // output register
  logic [SAMPLE_W-1:0] out_t1, out_t2;
  logic [SAMPLE_W-1:0] out_mix [MAX_CH];
  logic                out_be;

  // datapath wires
  logic [31:0]                a1_full, a2_full;
  logic [AW-1:0]              raddr;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic signed [ACC_W-1:0]    acc, acc_sum;
  logic signed [RND_W-1:0]    filt_sum;
  logic signed [SAMPLE_W-1:0] filt_new;
  logic [2*GAIN_REG_W-1:0]    g1_all, g2_all;
  logic [COEF_W-1:0]          g1_raw, g2_raw;
  logic [COEF_W-1:0]          damp_eff;

  assign out_free = !m_tvalid || m_tready;

  ttfe_seq #(.CHANNELS(CHANNELS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .out_free (out_free),
    .s_tready (s_tready),
    .ctrl     (ctrl)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_one_delay    <= DELAY_W'(1);
      tap_two_delay    <= DELAY_W'(1);
      feedback_gain    <= '0;
      damping_coeff    <= '0;
      tap_one_gains_lo <= '0;
      tap_one_gains_hi <= '0;
      tap_two_gains_lo <= '0;
      tap_two_gains_hi <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_ONE_DELAY:    tap_one_delay    <= cfg_data[DELAY_W-1:0];
        REG_TAP_TWO_DELAY:    tap_two_delay    <= cfg_data[DELAY_W-1:0];
        REG_FEEDBACK_GAIN:    feedback_gain    <= cfg_data[COEF_W-1:0];
        REG_DAMPING_COEFF:    damping_coeff    <= cfg_data[COEF_W-1:0];
        REG_TAP_ONE_GAINS_LO: tap_one_gains_lo <= cfg_data;
        REG_TAP_ONE_GAINS_HI: tap_one_gains_hi <= cfg_data;
        REG_TAP_TWO_GAINS_LO: tap_two_gains_lo <= cfg_data;
        REG_TAP_TWO_GAINS_HI: tap_two_gains_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // tap addresses, wrapped to the memory size
  assign a1_full = 32'(wp) - 32'(tap_one_delay);
  assign a2_full = 32'(wp) - 32'(tap_two_delay);
  assign raddr   = ctrl.rd_sel ? a2_full[AW-1:0] : a1_full[AW-1:0];

  ttfe_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .waddr (wp),
    .wdata (sat24(shift_q15(acc))),
    .re    (ctrl.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry is written once the pointer has passed it or wrapped
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_ok <= wrapped || (raddr < wp);
    end
  end

  assign rd_val = rd_ok ? rdata : '0;

  // gain fields, only positive gains contribute
  assign g1_all   = {tap_one_gains_hi, tap_one_gains_lo};
  assign g2_all   = {tap_two_gains_hi, tap_two_gains_lo};
  assign g1_raw   = g1_all[COEF_W*ctrl.gain_ch +: COEF_W];
  assign g2_raw   = g2_all[COEF_W*ctrl.gain_ch +: COEF_W];
  assign damp_eff = (damping_coeff > ONE_Q15) ? ONE_Q15 : damping_coeff;

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.op_sel)
      OP_F1: begin
        op_a = OPA_W'(h0) - OPA_W'(y);
        op_b = {1'b0, damp_eff};
      end
      OP_F2: begin
        op_a = OPA_W'(h1) - OPA_W'(y);
        op_b = {1'b0, damp_eff};
      end
      OP_FB: begin
        op_a = OPA_W'(y);
        op_b = {1'b0, feedback_gain};
      end
      OP_T1: begin
        op_a = OPA_W'(t1);
        op_b = g1_raw[COEF_W-1] ? '0 : {1'b0, g1_raw};
      end
      OP_T2: begin
        op_a = OPA_W'(t2);
        op_b = g2_raw[COEF_W-1] ? '0 : {1'b0, g2_raw};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ttfe_mac u_mac (
    .clk     (clk),
    .ctrl    (ctrl),
    .op_a    (op_a),
    .op_b    (op_b),
    .acc     (acc),
    .acc_sum (acc_sum)
  );

  // one-pole step stays between its input and history, no clamp needed
  assign filt_sum = RND_W'(y) + shift_q15(acc);
  assign filt_new = filt_sum[SAMPLE_W-1:0];

  // pointer, wrap flag and filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      h0      <= '0;
      h1      <= '0;
    end else begin
      if (ctrl.mem_we) begin
        wp <= wp + 1'b1;
        if (wp == '1) begin
          wrapped <= 1'b1;
        end
      end
      if (ctrl.upd_f1) begin
        h0 <= filt_new;
      end
      if (ctrl.upd_f2) begin
        h1 <= filt_new;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      x  <= s_tdata;
      be <= s_tlast;
    end
    if (ctrl.ld_tap1) begin
      t1 <= rd_val;
    end
    if (ctrl.ld_sum) begin
      t2 <= rd_val;
      y  <= sat24(RND_W'(rd_val) + RND_W'(x));
    end else if (ctrl.upd_f1 || ctrl.upd_f2) begin
      y <= filt_new;
    end
    if (ctrl.mix_we) begin
      mix_work[ctrl.mix_ch] <= sat24(shift_q15(acc_sum));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // unused channels load zero
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_t1 <= t1;
      out_t2 <= t2;
      out_be <= be;
      for (int k = 0; k < MAX_CH; k++) begin
        out_mix[k] <= (k < CHANNELS) ? mix_work[k] : '0;
      end
    end
  end

  for (genvar k = 0; k < MAX_CH; k++) begin : g_mix
    assign m_tdata[(k+2)*SAMPLE_W +: SAMPLE_W] = out_mix[k];
  end

  assign m_tdata[0 +: SAMPLE_W]        = out_t1;
  assign m_tdata[SAMPLE_W +: SAMPLE_W] = out_t2;
  assign m_tlast                       = out_be;

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!m_tvalid || m_tready))
    else $error("output register loaded over a waiting result");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    wrapped |=> wrapped)
    else $error("wrap flag dropped without reset");

  a_mix_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.mix_we |-> (32'(ctrl.mix_ch) < CHANNELS))
    else $error("mix written for a channel out of range");

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ttfe_pkg::*;

  localparam int MEM_LOG2 = DEF_DEPTH_LOG2;
  localparam int NUM_CH   = DEF_CHANNELS;
  localparam int RAND_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 105;

  // sample corners for the directed part
  localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [14] = '{
    24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h000000,
    24'h000001, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h400000, 24'hC00000, 24'h7FFFFF
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0]             tap1;
    logic [SAMPLE_W-1:0]             tap2;
    logic [MAX_CH-1:0][SAMPLE_W-1:0] mix;
    logic                            last;
  } echo_result_t;

  // Predicts the echo unit and holds the results still owed by it
  class echo_scoreboard;
    logic [DELAY_W-1:0]         tap_one_dly;
    logic [DELAY_W-1:0]         tap_two_dly;
    logic [COEF_W-1:0]          fb_gain;
    logic [COEF_W-1:0]          damp;
    logic [GAIN_REG_W-1:0]      tap_one_gains [2];
    logic [GAIN_REG_W-1:0]      tap_two_gains [2];
    logic signed [SAMPLE_W-1:0] echo_mem [1 << MEM_LOG2];
    logic [MEM_LOG2-1:0]        wr_ptr;
    longint                     lp_hist [2];
    echo_result_t               owed_results [$];
    int                         mismatch_count;
    int                         results_seen;

    function new();
      tap_one_dly = 1;
      tap_two_dly = 1;
      fb_gain = '0;
      damp = '0;
      tap_one_gains = '{default: '0};
      tap_two_gains = '{default: '0};
      foreach (echo_mem[i]) echo_mem[i] = '0;
      wr_ptr = '0;
      lp_hist = '{0, 0};
      mismatch_count = 0;
      results_seen = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_REG_W-1:0] val);
      case (idx)
        REG_TAP_ONE_DELAY:    tap_one_dly = val[DELAY_W-1:0];
        REG_TAP_TWO_DELAY:    tap_two_dly = val[DELAY_W-1:0];
        REG_FEEDBACK_GAIN:    fb_gain = val[COEF_W-1:0];
        REG_DAMPING_COEFF:    damp = val[COEF_W-1:0];
        REG_TAP_ONE_GAINS_LO: tap_one_gains[0] = val;
        REG_TAP_ONE_GAINS_HI: tap_one_gains[1] = val;
        REG_TAP_TWO_GAINS_LO: tap_two_gains[0] = val;
        REG_TAP_TWO_GAINS_HI: tap_two_gains[1] = val;
        default: ;
      endcase
    endfunction

    // Q1.15 round to nearest, halves up (arithmetic shift gives the floor)
    function longint q15_round(longint v);
      return (v + 64'sd16384) >>> 15;
    endfunction

    function longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic lst);
      longint x, t1, t2, a, y, acc, g1, g2;
      logic [MEM_LOG2-1:0] rd1, rd2;
      echo_result_t r;
      x = smp;
      rd1 = wr_ptr - tap_one_dly;
      rd2 = wr_ptr - tap_two_dly;
      t1 = echo_mem[rd1];
      t2 = echo_mem[rd2];
      a = (damp > ONE_Q15) ? longint'(ONE_Q15) : longint'(damp);
      // damping lowpass, two one-pole sections
      y = clamp24(t2 + x);
      y = y + q15_round((lp_hist[0] - y) * a);
      lp_hist[0] = y;
      y = y + q15_round((lp_hist[1] - y) * a);
      lp_hist[1] = y;
      echo_mem[wr_ptr] = SAMPLE_W'(clamp24(q15_round(y * longint'(fb_gain))));
      wr_ptr = wr_ptr + 1'b1;
      r.tap1 = t1[SAMPLE_W-1:0];
      r.tap2 = t2[SAMPLE_W-1:0];
      r.last = lst;
      // per-channel mix; non-positive gains add nothing
      for (int ch = 0; ch < MAX_CH; ch++) begin
        acc = 0;
        if (ch < NUM_CH) begin
          g1 = $signed(tap_one_gains[ch >> 2][16 * (ch & 3) +: 16]);
          g2 = $signed(tap_two_gains[ch >> 2][16 * (ch & 3) +: 16]);
          if (g1 > 0) acc += t1 * g1;
          if (g2 > 0) acc += t2 * g2;
          acc = clamp24(q15_round(acc));
        end
        r.mix[ch] = acc[SAMPLE_W-1:0];
      end
      owed_results.push_back(r);
    endfunction

    function void field_check(string name, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic lst);
      echo_result_t e;
      if (owed_results.size() == 0) begin
        $error("result with no sample pending: tdata %h tlast %b", data, lst);
        mismatch_count++;
        return;
      end
      e = owed_results.pop_front();
      results_seen++;
      field_check("tap_one_sample", e.tap1, data[0 +: SAMPLE_W]);
      field_check("tap_two_sample", e.tap2, data[SAMPLE_W +: SAMPLE_W]);
      for (int ch = 0; ch < MAX_CH; ch++) begin
        field_check($sformatf("channel_%0d_mix", ch), e.mix[ch],
                    data[(2 + ch) * SAMPLE_W +: SAMPLE_W]);
      end
      field_check("block_end_out", SAMPLE_W'(e.last), SAMPLE_W'(lst));
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;   // sample_in
  logic                  s_tlast = 1'b0; // block_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // tap_one_sample, tap_two_sample, channel_0_mix .. channel_7_mix
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;        // block_end_out
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [GAIN_REG_W-1:0] cfg_data = '0;

  echo_scoreboard        sb;
  logic [GAIN_REG_W-1:0] cfg_plan [8];
  bit                    src_idle_on = 1'b1;
  bit                    sink_idle_on = 1'b1;
  int                    sink_hold = 0;
  int                    samples_sent = 0;
  int                    settings_used = 0;

  two_tap_feedback_echo_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, long hold-off on request, check at each handshake
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_tready <= !(sink_idle_on && $urandom_range(99) < 33);
      end
    end
  end

  // write all eight registers from cfg_plan, block idle
  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= cfg_plan[i];
      @(posedge clk);
      sb.apply_reg(CFG_IDX_W'(i), cfg_plan[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    while (src_idle_on && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(smp, lst);
    samples_sent++;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain_results();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.mismatch_count += sb.pending();
      sb.owed_results.delete();
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {$urandom_range(1), {(SAMPLE_W-1){1'b0}}} - 24'd1;  // 0x7FFFFF or 0xFFFFFF
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}} + SAMPLE_W'($urandom_range(1));
      2, 3: return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: short taps, unity feedback, gains at their corners
    cfg_plan[REG_TAP_ONE_DELAY]    = 64'd1;
    cfg_plan[REG_TAP_TWO_DELAY]    = 64'd2;
    cfg_plan[REG_FEEDBACK_GAIN]    = 64'd32768;
    cfg_plan[REG_DAMPING_COEFF]    = 64'd0;
    cfg_plan[REG_TAP_ONE_GAINS_LO] = 64'h0001_0000_8000_7FFF;
    cfg_plan[REG_TAP_ONE_GAINS_HI] = 64'h2000_7FFF_4000_FFFF;
    cfg_plan[REG_TAP_TWO_GAINS_LO] = 64'h0000_4000_7FFF_7FFF;
    cfg_plan[REG_TAP_TWO_GAINS_HI] = 64'h0001_C000_7FFF_8000;
    program_regs();
    foreach (CORNER_SAMPLES[k]) send_sample(CORNER_SAMPLES[k], (k % 3) == 2);
    drain_results();

    // directed: zero delay, feedback and damping above one
    cfg_plan[REG_TAP_ONE_DELAY] = 64'd1;
    cfg_plan[REG_TAP_TWO_DELAY] = 64'd0;
    cfg_plan[REG_FEEDBACK_GAIN] = 64'hFFFF;
    cfg_plan[REG_DAMPING_COEFF] = 64'hFFFF;
    program_regs();
    for (int k = 0; k < 10; k++) send_sample(CORNER_SAMPLES[k], k[0]);
    drain_results();

    // random settings, first two at the extremes
    for (int ph = 0; ph < RAND_SETTINGS; ph++) begin
      if (ph == 0) begin
        cfg_plan[REG_TAP_ONE_DELAY] = 64'd0;
        cfg_plan[REG_TAP_TWO_DELAY] = 64'd32767;
        cfg_plan[REG_FEEDBACK_GAIN] = 64'd65535;
        cfg_plan[REG_DAMPING_COEFF] = 64'd32768;
      end else if (ph == 1) begin
        cfg_plan[REG_TAP_ONE_DELAY] = 64'd32767;
        cfg_plan[REG_TAP_TWO_DELAY] = 64'd1;
        cfg_plan[REG_FEEDBACK_GAIN] = 64'd0;
        cfg_plan[REG_DAMPING_COEFF] = 64'd65535;
      end else begin
        cfg_plan[REG_TAP_ONE_DELAY] = $urandom_range(1, 40);
        cfg_plan[REG_TAP_TWO_DELAY] = cfg_plan[REG_TAP_ONE_DELAY] + $urandom_range(0, 60);
        cfg_plan[REG_FEEDBACK_GAIN] = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                               : $urandom_range(32768);
        cfg_plan[REG_DAMPING_COEFF] = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                               : $urandom_range(32768);
      end
      for (int i = REG_TAP_ONE_GAINS_LO; i <= REG_TAP_TWO_GAINS_HI; i++) begin
        cfg_plan[i] = (ph == 1) ? 64'h7FFF_7FFF_7FFF_7FFF : {$urandom, $urandom};
      end
      program_regs();

      // one setting holds the results back long enough to fill the block
      if (ph == 2) sink_hold = 400;
      for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
        src_idle_on = !((k >= 60 && k < 90) || (ph == 2 && k < 30));
        sink_idle_on = !(k >= 60 && k < 90);
        send_sample(pick_sample(), $urandom_range(7) == 0);
      end
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      drain_results();
    end

    repeat (40) @(posedge clk);
    $display("%0d samples sent over %0d register settings, %0d results checked",
             samples_sent, settings_used, sb.results_seen);
    $display("covered sample extremes, zero and full delays, gain corners, long output stall");
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
